/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros, clocked on i_clk, reset by i_rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define AST_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AST_SAME(lbl, ante, cons)
`define AST_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/rbm_pkg.sv */
// ----------------------------------------------------------------------------
// rbm_pkg
// types and constants for the three-slot rom bank mapper
// ----------------------------------------------------------------------------
package rbm_pkg;

    localparam int RAM_BYTES_DEF = 16384;
    localparam int OFFSET_BITS   = 14;   // 16 KiB slot
    localparam int PAGE_BITS     = 4;
    localparam int ROM_ADDR_BITS = 18;

    // register select, low two address bits of a write at FFFC..FFFF
    localparam logic [1:0] SEL_CONTROL = 2'd0;
    localparam logic [1:0] SEL_PAGE0   = 2'd1;
    localparam logic [1:0] SEL_PAGE1   = 2'd2;
    localparam logic [1:0] SEL_PAGE2   = 2'd3;

    typedef struct packed {
        logic [23:0] bus_address;
        logic [7:0]  write_byte;
        logic        rom_select_n;
        logic        read_strobe_n;
        logic        write_strobe_n;
        logic        slot2_select_n;
    } t_in_item;

    typedef struct packed {
        logic                     rom_fetch;
        logic [ROM_ADDR_BITS-1:0] rom_byte_address;
        logic                     ram_fetch;
        logic [7:0]               ram_byte;
    } t_out_item;

    // decode result handed to the pipeline
    typedef struct packed {
        logic                     rom_fetch;
        logic [ROM_ADDR_BITS-1:0] rom_byte_address;
        logic                     ram_fetch;
        logic                     ram_wr;
    } t_dec_res;

endpackage

/* rtl/rbm_ram.sv */
// ----------------------------------------------------------------------------
// rbm_ram
// generic single-port ram, registered read, read-before-write
// ----------------------------------------------------------------------------
module rbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata <= r_mem[i_addr];
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/rbm_decode.sv */
// ----------------------------------------------------------------------------
// rbm_decode
// bus cycle decode, control byte and slot page registers
// ----------------------------------------------------------------------------
module rbm_decode #(
    parameter int RAM_BYTES = rbm_pkg::RAM_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_mapping_on,
    input  logic                         i_fire,
    input  rbm_pkg::t_in_item            i_item,
    output rbm_pkg::t_dec_res            o_res,
    output logic [$clog2(RAM_BYTES)-1:0] o_ram_idx
);

    localparam int AW = $clog2(RAM_BYTES);
    localparam int OB = rbm_pkg::OFFSET_BITS;
    localparam int PB = rbm_pkg::PAGE_BITS;

    logic [7:0]    r_control;
    logic [PB-1:0] r_page [3];

    logic          cart, ce, rd, wr, s2;
    logic [OB-1:0] offset;
    logic [PB-1:0] slot_page;
    logic [PB-1:0] page_val;
    logic          reg_wr;

    // offset modulo ram size, quotient is below 16 so four compare-subtract steps
    function automatic logic [AW-1:0] ram_index(input logic [OB-1:0] off);
        logic [20:0] v;
        v = 21'(off);
        for (int k = 3; k >= 0; k--) begin
            if (v >= (21'(RAM_BYTES) << k)) begin
                v = v - (21'(RAM_BYTES) << k);
            end
        end
        return v[AW-1:0];
    endfunction

    always_comb begin
        cart      = !i_item.bus_address[17];
        ce        = !i_item.rom_select_n;
        rd        = !i_item.read_strobe_n;
        wr        = !i_item.write_strobe_n;
        s2        = !i_item.slot2_select_n;
        offset    = i_item.bus_address[OB-1:0];
        slot_page = i_item.bus_address[OB] ? r_page[1] : r_page[0];

        o_res = '0;
        if (cart && rd) begin
            if (!i_mapping_on) begin
                if (ce) begin
                    o_res.rom_fetch        = 1'b1;
                    o_res.rom_byte_address = 18'(i_item.bus_address[14:0]);
                end
            end else if (ce) begin
                o_res.rom_fetch        = 1'b1;
                o_res.rom_byte_address = {slot_page, offset};
            end else if (s2) begin
                if (r_control[3]) begin
                    o_res.ram_fetch = 1'b1;
                end else begin
                    o_res.rom_fetch        = 1'b1;
                    o_res.rom_byte_address = {r_page[2], offset};
                end
            end
        end
        o_res.ram_wr = cart && wr && i_mapping_on && s2 && r_control[3];
        o_ram_idx    = ram_index(offset);

        // offset quirk: adding (4 - shift) * 8 modulo 16 flips bit 3 for odd shifts
        page_val = {i_item.write_byte[3] ^ r_control[0], i_item.write_byte[2:0]};
        reg_wr   = i_fire && cart && wr && i_mapping_on
                   && (i_item.bus_address[15:2] == 14'h3fff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control <= '0;
            r_page[0] <= PB'(0);
            r_page[1] <= PB'(1);
            r_page[2] <= PB'(2);
        end else if (reg_wr) begin
            case (i_item.bus_address[1:0])
                rbm_pkg::SEL_CONTROL: r_control <= i_item.write_byte;
                rbm_pkg::SEL_PAGE0:   r_page[0] <= page_val;
                rbm_pkg::SEL_PAGE1:   r_page[1] <= page_val;
                rbm_pkg::SEL_PAGE2:   r_page[2] <= page_val;
                default:              r_control <= r_control;
            endcase
        end
    end

endmodule

/* rtl/three_slot_rom_bank_mapper_with_ram.sv */
// ----------------------------------------------------------------------------
// three_slot_rom_bank_mapper_with_ram
// bank mapper for three 16 KiB rom slots with on-cart ram
// ----------------------------------------------------------------------------
//  channel  direction  handshake                   payload
//  in       input      i_in_valid / o_in_ready     i_in_data  (t_in_item)
//  out      output     o_out_valid / i_out_ready   o_out_data (t_out_item)
//  cfg      input      i_cfg_valid / o_cfg_ready   i_cfg_data (mapping_on)
//
//  one transaction per cycle unless the output stalls; each result goes
//  via the registered ram read of the accept cycle, then the output register
//  after reset the ram is cleared, one entry a cycle, with o_in_ready low
//  until every entry is written; cfg writes are taken throughout
//  a stalled output holds one result in the output register and one in the
//  read stage, then o_in_ready drops
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module three_slot_rom_bank_mapper_with_ram #(
    parameter int RAM_BYTES = rbm_pkg::RAM_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rbm_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rbm_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    localparam int AW = $clog2(RAM_BYTES);

    logic                r_mapping_on;
    logic                r_clr_busy;
    logic [AW-1:0]       r_clr_addr;
    logic                r_s1_valid;
    rbm_pkg::t_dec_res   r_s1;
    logic                r_out_valid;
    rbm_pkg::t_out_item  r_out;

    rbm_pkg::t_dec_res   dec;
    logic [AW-1:0]       dec_idx;
    logic                in_fire, s1_move;
    logic                ram_en, ram_we;
    logic [AW-1:0]       ram_addr;
    logic [7:0]          ram_wdata, ram_rdata;

    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_clr_busy && (!r_s1_valid || s1_move);
    assign in_fire    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    rbm_decode #(
        .RAM_BYTES (RAM_BYTES)
    ) u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mapping_on (r_mapping_on),
        .i_fire       (in_fire),
        .i_item       (i_in_data),
        .o_res        (dec),
        .o_ram_idx    (dec_idx)
    );

    // clearing sweep owns the ram port until done
    always_comb begin
        if (r_clr_busy) begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_en    = in_fire && (dec.ram_fetch || dec.ram_wr);
            ram_we    = in_fire && dec.ram_wr;
            ram_addr  = dec_idx;
            ram_wdata = i_in_data.write_byte;
        end
    end

    rbm_ram #(
        .WIDTH (8),
        .DEPTH (RAM_BYTES)
    ) u_cart_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mapping_on <= 1'b0;
            r_clr_busy   <= 1'b1;
            r_clr_addr   <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mapping_on <= i_cfg_data;
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(RAM_BYTES - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= dec;
        end
        if (s1_move) begin
            r_out.rom_fetch        <= r_s1.rom_fetch;
            r_out.rom_byte_address <= r_s1.rom_byte_address;
            r_out.ram_fetch        <= r_s1.ram_fetch;
            r_out.ram_byte         <= r_s1.ram_fetch ? ram_rdata : 8'h00;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `AST_SAME(a_no_accept_in_clear, r_clr_busy, !o_in_ready)
    `AST_SAME(a_one_source, o_out_valid, !(o_out_data.rom_fetch && o_out_data.ram_fetch))
    `AST_SAME(a_rom_addr_zero, o_out_valid && !o_out_data.rom_fetch,
              o_out_data.rom_byte_address == '0)
    `AST_SAME(a_ram_byte_zero, o_out_valid && !o_out_data.ram_fetch,
              o_out_data.ram_byte == 8'h00)
    `AST_NEXT(a_fire_fills_stage, in_fire, r_s1_valid)

endmodule
